// ===== src/spsq_pkg.sv =====
// ----------------------------------------------------------------------------
// spsq_pkg
// shared types and codes for the stable sorted priority queue unit
// ----------------------------------------------------------------------------
package spsq_pkg;

   // most results one display request may produce
   localparam int unsigned MAX_RESULTS = 16;

   typedef enum logic {
      REQ_INSERT  = 1'b0,
      REQ_DISPLAY = 1'b1
   } req_code_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_SHOWN    = 2'd2,
      ST_EMPTY    = 2'd3
   } status_code_type;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] item_value;
      logic [7:0]         item_rank;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic [7:0]         out_rank;
      logic [1:0]         status;
      logic               last;
   } rsp_payload_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic do_insert;
      logic do_rotate;
   } cell_ctrl_type;

endpackage

// ===== src/spsq_cell.sv =====
// ----------------------------------------------------------------------------
// spsq_cell
// one slot of the sorted chain: holds an entry, shifts right on insert,
// rotates left toward the head on display
// ----------------------------------------------------------------------------
module spsq_cell #(
   parameter int RANK_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spsq_pkg::cell_ctrl_type   ctrl,
   input  logic signed [31:0]        new_value,
   input  logic [RANK_BITS-1:0]      new_rank,
   input  logic                      left_gt,
   input  logic                      left_used,
   input  logic signed [31:0]        left_value,
   input  logic [RANK_BITS-1:0]      left_rank,
   input  logic                      right_used,
   input  logic signed [31:0]        right_value,
   input  logic [RANK_BITS-1:0]      right_rank,
   input  logic signed [31:0]        head_value,
   input  logic [RANK_BITS-1:0]      head_rank,
   output logic                      gt,
   output logic                      used,
   output logic signed [31:0]        value,
   output logic [RANK_BITS-1:0]      rank
);
   import spsq_pkg::*;

   logic                 used_ff, used_in;
   logic signed [31:0]   value_ff, value_in;
   logic [RANK_BITS-1:0] rank_ff, rank_in;

   // new entry goes at or before this slot
   assign gt = !used_ff || (rank_ff > new_rank);

   always_comb begin
      used_in  = used_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      if (ctrl.do_insert) begin
         if (left_gt) begin
            used_in  = left_used;
            value_in = left_value;
            rank_in  = left_rank;
         end else if (gt) begin
            used_in  = 1'b1;
            value_in = new_value;
            rank_in  = new_rank;
         end
      end else if (ctrl.do_rotate) begin
         if (right_used) begin
            value_in = right_value;
            rank_in  = right_rank;
         end else if (used_ff) begin
            // tail of the used prefix wraps to the head
            value_in = head_value;
            rank_in  = head_rank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

   assign used  = used_ff;
   assign value = value_ff;
   assign rank  = rank_ff;

endmodule

// ===== src/stable_sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// bounded priority queue kept sorted by rank in a chain of cells, equal
// ranks in arrival order; insert and in-order display requests
// ----------------------------------------------------------------------------
//
//   channel   ports                        transfer when
//   -------   --------------------------   ------------------------------
//   request   start, busy, req_data        start high and busy low
//   result    rsp_valid, rsp_data          rsp_valid high (one cycle)
//
// on an insert every cell compares its rank against the new one and shifts
// right in parallel, so inserts can follow back to back and the result
// appears the cycle after the transfer
// a display of n stored entries rotates the chain once per cycle, showing
// the head each time; busy stays high while the chain rotates
// (at most 16 results, rotation always runs the full n to restore order)
// an empty display gives one result and does not raise busy
// reset clears the used bits and the entry count, no clearing pass
// the receiver cannot stall: each result is on the ports for one cycle
//
module stable_sorted_priority_queue_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int RANK_BITS   = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  spsq_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   output spsq_pkg::rsp_payload_type rsp_data
);
   import spsq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // chain taps
   logic                 cell_gt    [QUEUE_DEPTH];
   logic                 cell_used  [QUEUE_DEPTH];
   logic signed [31:0]   cell_value [QUEUE_DEPTH];
   logic [RANK_BITS-1:0] cell_rank  [QUEUE_DEPTH];

   cell_ctrl_type        ctrl;
   logic [RANK_BITS-1:0] new_rank;

   // control registers
   logic            busy_ff, busy_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   step_ff, step_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          full;
   logic [CW-1:0] show_lim;

   // only the low RANK_BITS of the request rank take part
   assign new_rank = RANK_BITS'(req_data.item_rank);

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CW'(QUEUE_DEPTH));

   // a display shows at most MAX_RESULTS entries
   always_comb begin
      if (32'(count_ff) > MAX_RESULTS) begin
         show_lim = CW'(MAX_RESULTS);
      end else begin
         show_lim = count_ff;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      ctrl         = '0;

      if (busy_ff) begin
         // display in progress: show the head, then rotate the chain
         ctrl.do_rotate = 1'b1;
         step_in        = step_ff + CW'(1);
         if (step_ff < show_lim) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.out_value = cell_value[0];
            rsp_data_in.out_rank  = 8'(cell_rank[0]);
            rsp_data_in.status    = ST_SHOWN;
            rsp_data_in.last      = (step_ff == show_lim - CW'(1));
         end
         if (step_ff == count_ff - CW'(1)) begin
            busy_in = 1'b0;
         end
      end else if (accept) begin
         unique case (req_code_type'(req_data.req_type))
            REQ_INSERT: begin
               rsp_valid_in     = 1'b1;
               rsp_data_in.last = 1'b1;
               if (full) begin
                  rsp_data_in.status = ST_DROPPED;
               end else begin
                  rsp_data_in.status = ST_INSERTED;
                  ctrl.do_insert     = 1'b1;
                  count_in           = count_ff + CW'(1);
               end
            end
            REQ_DISPLAY: begin
               if (count_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = ST_EMPTY;
                  rsp_data_in.last   = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  step_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // the chain itself
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 l_gt, l_used, r_used;
      logic signed [31:0]   l_value, r_value;
      logic [RANK_BITS-1:0] l_rank, r_rank;

      if (i == 0) begin : g_head
         assign l_gt    = 1'b0;
         assign l_used  = 1'b0;
         assign l_value = '0;
         assign l_rank  = '0;
      end else begin : g_mid
         assign l_gt    = cell_gt[i-1];
         assign l_used  = cell_used[i-1];
         assign l_value = cell_value[i-1];
         assign l_rank  = cell_rank[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_used  = 1'b0;
         assign r_value = '0;
         assign r_rank  = '0;
      end else begin : g_body
         assign r_used  = cell_used[i+1];
         assign r_value = cell_value[i+1];
         assign r_rank  = cell_rank[i+1];
      end

      spsq_cell #(
         .RANK_BITS (RANK_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_value   (req_data.item_value),
         .new_rank    (new_rank),
         .left_gt     (l_gt),
         .left_used   (l_used),
         .left_value  (l_value),
         .left_rank   (l_rank),
         .right_used  (r_used),
         .right_value (r_value),
         .right_rank  (r_rank),
         .head_value  (cell_value[0]),
         .head_rank   (cell_rank[0]),
         .gt          (cell_gt[i]),
         .used        (cell_used[i]),
         .value       (cell_value[i]),
         .rank        (cell_rank[i])
      );
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== verif/spsq_order_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spsq_order_checker
// watches the request and result channels of the priority queue unit, keeps
// its own sorted copy of the queue and compares every result in order
// ----------------------------------------------------------------------------
module spsq_order_checker #(
   parameter int QUEUE_DEPTH = 16,
   parameter int RANK_BITS   = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  spsq_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  spsq_pkg::rsp_payload_type rsp_data,
   output int                        fail_count,
   output int                        pending_count
);
   import spsq_pkg::*;

   localparam logic [31:0] RANK_MASK = 32'((64'd1 << RANK_BITS) - 64'd1);

   logic [31:0]     entry_value [QUEUE_DEPTH];
   logic [31:0]     entry_rank  [QUEUE_DEPTH];
   int              entry_count = 0;
   rsp_payload_type expected_rsp [$];
   int              mismatches = 0;

   function automatic rsp_payload_type make_rsp(input logic [31:0] value,
                                                input logic [7:0] rank,
                                                input status_code_type status,
                                                input logic last);
      rsp_payload_type r;
      r.out_value = value;
      r.out_rank  = rank;
      r.status    = status;
      r.last      = last;
      return r;
   endfunction

   // update the shadow queue and queue up the results one request causes
   function automatic void predict_request(input req_payload_type item);
      logic [31:0] rank;
      int          slot;
      int          shown;
      rank = 32'(item.item_rank) & RANK_MASK;
      if (item.req_type == REQ_INSERT) begin
         if (entry_count >= QUEUE_DEPTH) begin
            expected_rsp.push_back(make_rsp('0, '0, ST_DROPPED, 1'b1));
         end else begin
            // after every entry of lower or equal rank
            slot = 0;
            while (slot < entry_count && entry_rank[slot] <= rank) slot++;
            for (int i = entry_count; i > slot; i--) begin
               entry_value[i] = entry_value[i-1];
               entry_rank[i]  = entry_rank[i-1];
            end
            entry_value[slot] = item.item_value;
            entry_rank[slot]  = rank;
            entry_count++;
            expected_rsp.push_back(make_rsp('0, '0, ST_INSERTED, 1'b1));
         end
      end else if (entry_count == 0) begin
         expected_rsp.push_back(make_rsp('0, '0, ST_EMPTY, 1'b1));
      end else begin
         shown = (entry_count > MAX_RESULTS) ? MAX_RESULTS : entry_count;
         for (int i = 0; i < shown; i++) begin
            expected_rsp.push_back(make_rsp(entry_value[i], entry_rank[i][7:0], ST_SHOWN,
                                            i == shown - 1));
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         entry_count = 0;
         expected_rsp.delete();
      end else begin
         // result on the ports belongs to an earlier request than any taken now
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result: out_value %0d out_rank %0d status %0d last %0d",
                      rsp_data.out_value, rsp_data.out_rank, rsp_data.status, rsp_data.last);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.out_value !== want.out_value) begin
                  $error("out_value: expected %0d, got %0d", want.out_value,
                         rsp_data.out_value);
                  mismatches++;
               end
               if (rsp_data.out_rank !== want.out_rank) begin
                  $error("out_rank: expected %0d, got %0d", want.out_rank, rsp_data.out_rank);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  mismatches++;
               end
            end
         end
         if (start && !busy) predict_request(req_data);
      end
      fail_count    <= mismatches;
      pending_count <= expected_rsp.size();
   end

endmodule

// ===== verif/tb_stable_sorted_priority_queue_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue_unit
// drives insert and display requests into the priority queue unit, with
// random sender idling in three phases; a checker beside the unit predicts
// the sorted contents and compares every result
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue_unit;
   import spsq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANK_BITS    = 8;
   localparam int PHASE_ITEMS  = 63;    // random requests per idling phase
   localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all
   localparam int DRAIN_CYCLES = 24;    // quiet time after the last result

   logic            clock = 1'b0;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_data;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   int fail_count;
   int pending_count;
   int idle_pct     = 19;
   int stall_cycles = 0;

   always #6 clock = ~clock;

   stable_sorted_priority_queue_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .RANK_BITS   (RANK_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   spsq_order_checker #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .RANK_BITS   (RANK_BITS)
   ) order_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // one request transfer; called right after a rising edge, returns right
   // after the edge that took the request
   task automatic send_request(input req_code_type kind, input logic [31:0] value,
                               input logic [7:0] rank);
      // random idle cycles before the request, start low while idling
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{req_type: kind, item_value: value, item_rank: rank};
      // busy is sampled before the unit updates it at this edge
      do @(posedge clock); while (busy);
   endtask

   // watchdog: any transfer on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: empty display, extreme values and ranks, ties kept
      // in arrival order, then fill to the brim and hit the full queue
      send_request(REQ_DISPLAY, 32'h0000_0000, 8'd0);
      send_request(REQ_INSERT, 32'h7FFF_FFFF, 8'd100);
      send_request(REQ_INSERT, 32'h8000_0000, 8'd100);   // tie goes behind
      send_request(REQ_INSERT, 32'h0000_0000, 8'd0);     // new head
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 8'd255);   // new tail
      send_request(REQ_INSERT, 32'h0000_0001, 8'd100);   // third of a tie
      send_request(REQ_DISPLAY, 32'hFFFF_FFFF, 8'd255);
      // eleven more around rank 100 so ties and middle inserts are common
      repeat (11) send_request(REQ_INSERT, $urandom, 8'($urandom_range(98, 102)));
      send_request(REQ_DISPLAY, 32'h0, 8'd0);            // full queue, all shown
      send_request(REQ_INSERT, 32'h1234_5678, 8'd0);     // dropped, would be head
      send_request(REQ_INSERT, 32'h8765_4321, 8'd255);   // dropped, would be tail
      send_request(REQ_DISPLAY, 32'h0, 8'd0);            // contents unchanged

      // random part, three idling phases: light, heavy, none
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 19 : (phase == 1) ? 46 : 0;
         repeat (PHASE_ITEMS) begin
            send_request($urandom_range(1) ? REQ_DISPLAY : REQ_INSERT, $urandom,
                         8'($urandom_range(255)));
         end
      end
      start <= 1'b0;

      // wait for every predicted result, then a quiet tail for strays
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      // every predicted result must have shown up as well
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/spsq_pkg.sv
src/spsq_cell.sv
src/stable_sorted_priority_queue_unit.sv
verif/spsq_order_checker.sv
verif/tb_stable_sorted_priority_queue_unit.sv
